>>> sv/cpu8_alu_with_status_flags_top_macros.svh
// Assertion macros shared by the ALU block.
`ifndef CPU8_ALU_WITH_STATUS_FLAGS_TOP_MACROS_SVH
`define CPU8_ALU_WITH_STATUS_FLAGS_TOP_MACROS_SVH

// Check a property on every edge outside reset.
`define C8ALU_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define C8ALU_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/c8alu_pkg.sv
// Shared types, operation codes and class codes of the 8-bit ALU.
`default_nettype none
package c8alu_pkg;

  // Request operation codes
  localparam logic [3:0] OP_ORA = 4'd0;
  localparam logic [3:0] OP_AND = 4'd1;
  localparam logic [3:0] OP_EOR = 4'd2;
  localparam logic [3:0] OP_ADC = 4'd3;
  localparam logic [3:0] OP_LDA = 4'd4;
  localparam logic [3:0] OP_CMP = 4'd5;
  localparam logic [3:0] OP_SBC = 4'd6;
  localparam logic [3:0] OP_ASL = 4'd7;
  localparam logic [3:0] OP_LSR = 4'd8;
  localparam logic [3:0] OP_ROL = 4'd9;
  localparam logic [3:0] OP_ROR = 4'd10;
  localparam logic [3:0] OP_INC = 4'd11;
  localparam logic [3:0] OP_DEC = 4'd12;
  localparam logic [3:0] OP_BRT = 4'd13;

  // Execution classes
  localparam logic [2:0] CLS_NOP    = 3'd0;
  localparam logic [2:0] CLS_LOGIC  = 3'd1;
  localparam logic [2:0] CLS_ADD    = 3'd2;
  localparam logic [2:0] CLS_LDA    = 3'd3;
  localparam logic [2:0] CLS_CMP    = 3'd4;
  localparam logic [2:0] CLS_SHIFT  = 3'd5;
  localparam logic [2:0] CLS_INCDEC = 3'd6;
  localparam logic [2:0] CLS_BRANCH = 3'd7;

  // Sub-operation codes within a class
  localparam logic [1:0] SUB_OR  = 2'd0;
  localparam logic [1:0] SUB_AND = 2'd1;
  localparam logic [1:0] SUB_EOR = 2'd2;
  localparam logic [1:0] SUB_ASL = 2'd0;
  localparam logic [1:0] SUB_LSR = 2'd1;
  localparam logic [1:0] SUB_ROL = 2'd2;
  localparam logic [1:0] SUB_ROR = 2'd3;
  localparam logic [1:0] SUB_INC = 2'd0;
  localparam logic [1:0] SUB_DEC = 2'd1;

  // Flag bit positions in the status register
  localparam int FLAG_N = 3;
  localparam int FLAG_V = 2;
  localparam int FLAG_Z = 1;
  localparam int FLAG_C = 0;

  // Branch condition flag selects (condition bits 2:1)
  localparam logic [1:0] BSEL_N = 2'd0;
  localparam logic [1:0] BSEL_V = 2'd1;
  localparam logic [1:0] BSEL_C = 2'd2;
  localparam logic [1:0] BSEL_Z = 2'd3;

  // Default queue depth between front and back
  localparam int Q_DEPTH = 2;

  // Decoded item handed from front to back
  typedef struct packed {
    logic [2:0] cls;
    logic [1:0] sub;
    logic [7:0] operand;
    logic       use_acc;
    logic [2:0] cond;
  } uop_t;

endpackage
`default_nettype wire

>>> sv/c8alu_front.sv
// Front end: accepts request items and decodes them into execution classes.
`default_nettype none
module c8alu_front
  import c8alu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] req_type,
  input  wire logic [7:0] operand,
  input  wire logic       use_accumulator,
  input  wire logic [2:0] branch_cond,
  output logic            push,
  input  wire logic       q_ready,
  output uop_t            push_uop
);

  logic fv;
  uop_t uop;
  uop_t dec;

  // Classify the request; SBC gets its operand complemented here
  always_comb begin
    dec.cls     = CLS_NOP;
    dec.sub     = SUB_OR;
    dec.operand = operand;
    dec.use_acc = use_accumulator;
    dec.cond    = branch_cond;
    unique case (req_type)
      OP_ORA: begin dec.cls = CLS_LOGIC; dec.sub = SUB_OR; end
      OP_AND: begin dec.cls = CLS_LOGIC; dec.sub = SUB_AND; end
      OP_EOR: begin dec.cls = CLS_LOGIC; dec.sub = SUB_EOR; end
      OP_ADC: dec.cls = CLS_ADD;
      OP_LDA: dec.cls = CLS_LDA;
      OP_CMP: dec.cls = CLS_CMP;
      OP_SBC: begin dec.cls = CLS_ADD; dec.operand = ~operand; end
      OP_ASL: begin dec.cls = CLS_SHIFT; dec.sub = SUB_ASL; end
      OP_LSR: begin dec.cls = CLS_SHIFT; dec.sub = SUB_LSR; end
      OP_ROL: begin dec.cls = CLS_SHIFT; dec.sub = SUB_ROL; end
      OP_ROR: begin dec.cls = CLS_SHIFT; dec.sub = SUB_ROR; end
      OP_INC: begin dec.cls = CLS_INCDEC; dec.sub = SUB_INC; end
      OP_DEC: begin dec.cls = CLS_INCDEC; dec.sub = SUB_DEC; end
      OP_BRT: dec.cls = CLS_BRANCH;
      default: dec.cls = CLS_NOP;
    endcase
  end

  // Decode register: refills in the cycle it drains into the queue
  assign in_ready = !fv || q_ready;
  assign push     = fv;
  assign push_uop = uop;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (q_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      uop <= dec;
    end
  end

endmodule
`default_nettype wire

>>> sv/c8alu_queue.sv
// Short FIFO of decoded items between front and back.
`default_nettype none
`include "cpu8_alu_with_status_flags_top_macros.svh"
module c8alu_queue
  import c8alu_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      q_ready,
  input  wire uop_t push_uop,
  output logic      q_valid,
  input  wire logic pop,
  output uop_t      pop_uop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uop_t          slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_ready = (count != CW'(DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;
  assign pop_uop = slots[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_uop;
    end
  end

  `C8ALU_ASSERT(a_q_grow, clk, rst, (do_push && !do_pop) |=> (count == $past(count) + 1'b1), "queue count did not grow on push")
  `C8ALU_ASSERT(a_q_drain, clk, rst, (do_pop && !do_push && count == CW'(1)) |=> !q_valid, "queue not empty after last item left")

endmodule
`default_nettype wire

>>> sv/c8alu_back.sv
// Back end: executes decoded items against accumulator and flags.
`default_nettype none
`include "cpu8_alu_with_status_flags_top_macros.svh"
module c8alu_back
  import c8alu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       pop,
  input  wire uop_t  pop_uop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] acc_out,
  output logic [7:0] result_byte,
  output logic       flag_negative,
  output logic       flag_overflow,
  output logic       flag_zero,
  output logic       flag_carry,
  output logic       branch_taken
);

  logic [7:0] acc;
  logic [3:0] flags;
  logic [7:0] acc_next;
  logic [3:0] flags_next;
  logic [7:0] res;
  logic       taken;
  logic [7:0] src;
  logic [8:0] total;
  logic [8:0] diff;
  logic       sel_bit;
  logic       cin;

  assign pop = q_valid && (!out_valid || out_ready);
  assign cin = flags[FLAG_C];
  assign src = pop_uop.use_acc ? acc : pop_uop.operand;

  // Adder and comparator
  assign total = {1'b0, acc} + {1'b0, pop_uop.operand} + {8'd0, cin};
  assign diff  = {1'b0, acc} - {1'b0, pop_uop.operand};

  // Execute one item
  always_comb begin
    acc_next   = acc;
    flags_next = flags;
    res        = 8'd0;
    taken      = 1'b0;
    sel_bit    = 1'b0;
    unique case (pop_uop.cls)
      CLS_NOP: ;
      CLS_LOGIC: begin
        unique case (pop_uop.sub)
          SUB_OR:  acc_next = acc | pop_uop.operand;
          SUB_AND: acc_next = acc & pop_uop.operand;
          default: acc_next = acc ^ pop_uop.operand;
        endcase
        flags_next[FLAG_N] = acc_next[7];
        flags_next[FLAG_Z] = (acc_next == 8'd0);
      end
      CLS_ADD: begin
        acc_next = total[7:0];
        flags_next[FLAG_V] = ~(acc[7] ^ pop_uop.operand[7]) & (acc[7] ^ total[7]);
        flags_next[FLAG_C] = total[8];
        flags_next[FLAG_N] = total[7];
        flags_next[FLAG_Z] = (total[7:0] == 8'd0);
      end
      CLS_LDA: begin
        acc_next = pop_uop.operand;
        flags_next[FLAG_N] = pop_uop.operand[7];
        flags_next[FLAG_Z] = (pop_uop.operand == 8'd0);
      end
      CLS_CMP: begin
        flags_next[FLAG_N] = diff[7];
        flags_next[FLAG_Z] = (acc == pop_uop.operand);
        flags_next[FLAG_C] = !diff[8];
      end
      CLS_SHIFT: begin
        unique case (pop_uop.sub)
          SUB_ASL: res = {src[6:0], 1'b0};
          SUB_LSR: res = {1'b0, src[7:1]};
          SUB_ROL: res = {src[6:0], cin};
          default: res = {cin, src[7:1]};
        endcase
        flags_next[FLAG_C] = (pop_uop.sub == SUB_ASL || pop_uop.sub == SUB_ROL) ?
                             src[7] : src[0];
        flags_next[FLAG_N] = res[7];
        flags_next[FLAG_Z] = (res == 8'd0);
        if (pop_uop.use_acc) begin
          acc_next = res;
        end
      end
      CLS_INCDEC: begin
        res = (pop_uop.sub == SUB_INC) ? pop_uop.operand + 8'd1 : pop_uop.operand - 8'd1;
        flags_next[FLAG_N] = res[7];
        flags_next[FLAG_Z] = (res == 8'd0);
      end
      CLS_BRANCH: begin
        unique case (pop_uop.cond[2:1])
          BSEL_N: sel_bit = flags[FLAG_N];
          BSEL_V: sel_bit = flags[FLAG_V];
          BSEL_C: sel_bit = flags[FLAG_C];
          default: sel_bit = flags[FLAG_Z];
        endcase
        taken = (sel_bit == pop_uop.cond[0]);
      end
      default: ;
    endcase
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'd0;
      flags <= 4'd0;
    end else if (pop) begin
      acc   <= acc_next;
      flags <= flags_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_out       <= acc_next;
      result_byte   <= res;
      flag_negative <= flags_next[FLAG_N];
      flag_overflow <= flags_next[FLAG_V];
      flag_zero     <= flags_next[FLAG_Z];
      flag_carry    <= flags_next[FLAG_C];
      branch_taken  <= taken;
    end
  end

  `C8ALU_ASSERT_ALWAYS(a_state_reset, clk, rst |=> (acc == 8'd0 && flags == 4'd0), "state not cleared by reset")
  `C8ALU_ASSERT(a_v_only_add, clk, rst, (pop && pop_uop.cls != CLS_ADD) |=> (flags[FLAG_V] == $past(flags[FLAG_V])), "overflow changed outside add")

endmodule
`default_nettype wire

>>> sv/cpu8_alu_with_status_flags_top.sv
// 6502-style 8-bit ALU with accumulator and N, V, Z, C status flags.
// The block sustains one item per cycle while out_ready holds: items pass a
// decode register, a short queue and the execute stage with its output
// register, in that order, before a result shows up. The rate is set by the
// execute stage, where accumulator and flags feed back into the next
// operation. The queue lets the front keep accepting while the output side
// stalls; up to QDEPTH + 2 items are held, counting the decode register and
// the output register.
// Reset clears the accumulator and all flags.
`default_nettype none
module cpu8_alu_with_status_flags_top
  import c8alu_pkg::*;
#(
  parameter int QDEPTH = Q_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] req_type,
  input  wire logic [7:0] operand,
  input  wire logic       use_accumulator,
  input  wire logic [2:0] branch_cond,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      acc_out,
  output logic [7:0]      result_byte,
  output logic            flag_negative,
  output logic            flag_overflow,
  output logic            flag_zero,
  output logic            flag_carry,
  output logic            branch_taken
);

  logic push;
  logic q_ready;
  logic q_valid;
  logic pop;
  uop_t push_uop;
  uop_t pop_uop;

  // Decode
  c8alu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .operand         (operand),
    .use_accumulator (use_accumulator),
    .branch_cond     (branch_cond),
    .push            (push),
    .q_ready         (q_ready),
    .push_uop        (push_uop)
  );

  // Decoupling queue
  c8alu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .q_ready  (q_ready),
    .push_uop (push_uop),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_uop  (pop_uop)
  );

  // Execute
  c8alu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .pop           (pop),
    .pop_uop       (pop_uop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .acc_out       (acc_out),
    .result_byte   (result_byte),
    .flag_negative (flag_negative),
    .flag_overflow (flag_overflow),
    .flag_zero     (flag_zero),
    .flag_carry    (flag_carry),
    .branch_taken  (branch_taken)
  );

endmodule
`default_nettype wire
